/* hdl/hmpn_pkg.sv */
// ============================================================================
// hmpn_pkg: shared types and constants of the heatmap peak finder
// geometry, window size, config codes and the result item format
// ============================================================================
`default_nettype none

package hmpn_pkg;

    localparam int WINDOW       = 20;
    localparam int HALF_WIN     = WINDOW / 2;
    localparam int HMAX_LINES   = WINDOW - 1;
    localparam int CENTER_LINES = WINDOW - HALF_WIN;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;

    localparam int PIX_W    = 16;
    localparam int THR_W    = 15;
    localparam int MARGIN_W = 8;
    localparam int GEOM_W   = 9;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int SLOT_H_W = $clog2(HMAX_LINES);
    localparam int SLOT_C_W = $clog2(CENTER_LINES);
    localparam int CDEPTH   = CENTER_LINES * MAX_WIDTH;
    localparam int CADDR_W  = $clog2(CDEPTH);

    // max reduction tree: groups of four per stage
    localparam int GRP   = 4;
    localparam int HGRPS = (WINDOW + GRP - 1) / GRP;
    localparam int VGRPS = (HMAX_LINES + GRP - 1) / GRP;

    localparam int PIPE_DEPTH  = 3;
    localparam int INFLIGHT_W  = $clog2(PIPE_DEPTH + 1);
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_THRESHOLD = 2'd2,
        CFG_MARGIN    = 2'd3
    } cfg_idx_t;

    typedef logic signed [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [GEOM_W-1:0]   width;
        logic [GEOM_W-1:0]   height;
        logic [THR_W-1:0]    threshold;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    typedef struct packed {
        logic             is_keypoint;
        logic [COL_W-1:0] peak_x;
        logic [ROW_W-1:0] peak_y;
        logic             frame_end;
    } result_t;

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

/* hdl/hmpn_ram.sv */
// ============================================================================
// hmpn_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ============================================================================
`default_nettype none

module hmpn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/hmpn_front.sv */
// ============================================================================
// hmpn_front: pixel intake, window maxima and peak classification
// counts raster position, keeps line buffers and decides each center
// ============================================================================
`default_nettype none

module hmpn_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hmpn_pkg::cfg_t                    cfg,
    input  wire logic                              accept,
    input  wire logic signed [hmpn_pkg::PIX_W-1:0] pixel_value,
    input  wire logic                              frame_last,
    output logic                                   push_valid,
    output hmpn_pkg::result_t                      push_item,
    output logic [hmpn_pkg::INFLIGHT_W-1:0]        inflight
);
    import hmpn_pkg::*;

    // position counters
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [SLOT_H_W-1:0] slot_h_reg, slot_h_next;
    logic [SLOT_C_W-1:0] slot_c_reg, slot_c_next;
    logic [COL_W:0]      col_inc;
    logic [ROW_W:0]      row_inc;

    pix_t win_reg  [WINDOW];
    pix_t win_next [WINDOW];
    pix_t pix_z;
    pix_t hgrp     [HGRPS];

    logic             h_ok, v_ok, pos_ok;
    logic [COL_W-1:0] cc, cc_rd;
    logic [ROW_W-1:0] cr;
    logic [SLOT_C_W-1:0] slot_c_rd;

    // stage 1
    logic                v1_reg, last1_reg, pos1_reg, hw1_reg;
    logic [SLOT_H_W-1:0] slot1_reg;
    logic [COL_W-1:0]    col1_reg, cc1_reg;
    logic [ROW_W-1:0]    cr1_reg;
    pix_t                hgrp1_reg [HGRPS];
    logic [PIX_W-1:0]    line_q    [HMAX_LINES];
    logic [PIX_W-1:0]    cq;

    // stage 2
    logic                v2_reg, last2_reg, pos2_reg, hw2_reg;
    logic [SLOT_H_W-1:0] slot2_reg;
    logic [COL_W-1:0]    col2_reg, cc2_reg;
    logic [ROW_W-1:0]    cr2_reg;
    pix_t                hmax2_reg, cv2_reg;
    pix_t                vgrp2_reg [VGRPS];
    pix_t                hmax1;
    pix_t                vgrp1 [VGRPS];

    // stage 3
    logic             v3_reg, last3_reg, pos3_reg;
    logic [COL_W-1:0] cc3_reg;
    logic [ROW_W-1:0] cr3_reg;
    pix_t             cv3_reg, vmax3_reg;
    pix_t             vmax2;
    logic             key;

    pix_t thr_s;
    assign thr_s = $signed({1'b0, cfg.threshold});
    assign pix_z = (pixel_value < thr_s) ? '0 : pixel_value;

    // next window and first level of the horizontal max tree
    always_comb
    begin
        pix_t m;
        for (int i = 0; i < WINDOW - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WINDOW - 1] = pix_z;
        for (int g = 0; g < HGRPS; g++)
        begin
            m = win_next[g * GRP];
            for (int k = 1; k < GRP; k++)
            begin
                if (g * GRP + k < WINDOW)
                begin
                    m = max2(m, win_next[g * GRP + k]);
                end
            end
            hgrp[g] = m;
        end
    end

    // counter update
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        slot_h_next = slot_h_reg;
        slot_c_next = slot_c_reg;
        if (frame_last)
        begin
            col_next    = '0;
            row_next    = '0;
            slot_h_next = '0;
            slot_c_next = '0;
        end
        else if (col_inc >= cfg.width)
        begin
            col_next = '0;
            if (row_inc >= cfg.height)
            begin
                row_next    = '0;
                slot_h_next = '0;
                slot_c_next = '0;
            end
            else
            begin
                row_next    = row_inc[ROW_W-1:0];
                slot_h_next = (slot_h_reg == SLOT_H_W'(HMAX_LINES - 1)) ? '0 : slot_h_reg + 1'b1;
                slot_c_next = (slot_c_reg == SLOT_C_W'(CENTER_LINES - 1)) ? '0 : slot_c_reg + 1'b1;
            end
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            slot_h_reg <= '0;
            slot_c_reg <= '0;
        end
        else if (accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_h_reg <= slot_h_next;
            slot_c_reg <= slot_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // center position and border checks
    assign h_ok = (col_reg >= COL_W'(WINDOW - 1));
    assign v_ok = h_ok && (row_reg >= ROW_W'(WINDOW - 1));
    assign cc   = col_reg - COL_W'(WINDOW - 1 - HALF_WIN);
    assign cr   = row_reg - ROW_W'(WINDOW - 1 - HALF_WIN);

    always_comb
    begin
        pos_ok = v_ok
            && (cr >= ROW_W'(HALF_WIN))
            && (cc >= COL_W'(HALF_WIN))
            && (({2'b0, cr} + 10'(HALF_WIN)) < {1'b0, cfg.height})
            && (({2'b0, cc} + 10'(HALF_WIN)) < {1'b0, cfg.width})
            && ({1'b0, cc} >= {1'b0, cfg.margin})
            && ({1'b0, cr} >= {1'b0, cfg.margin})
            && (({2'b0, cr} + {2'b0, cfg.margin}) < {1'b0, cfg.height})
            && (({2'b0, cc} + {2'b0, cfg.margin}) < {1'b0, cfg.width});
    end

    // center delay buffer: row slot of (row+1) holds the center row
    assign slot_c_rd = (slot_c_reg == SLOT_C_W'(CENTER_LINES - 1)) ? '0 : slot_c_reg + 1'b1;
    assign cc_rd     = cc;

    hmpn_ram #(
        .WIDTH (PIX_W),
        .DEPTH (CDEPTH)
    ) u_center_ram (
        .clk   (clk),
        .we    (accept),
        .waddr ({slot_c_reg, col_reg}),
        .wdata (pix_z),
        .raddr ({slot_c_rd, cc_rd}),
        .rdata (cq)
    );

    // horizontal maxima of the last rows, one ram per row slot
    for (genvar gi = 0; gi < HMAX_LINES; gi++)
    begin : g_line
        hmpn_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line_ram (
            .clk   (clk),
            .we    (v2_reg && hw2_reg && (slot2_reg == SLOT_H_W'(gi))),
            .waddr (col2_reg),
            .wdata (hmax2_reg),
            .raddr (col_reg),
            .rdata (line_q[gi])
        );
    end

    // stage 1 to stage 2 reduction
    always_comb
    begin
        pix_t m;
        hmax1 = hgrp1_reg[0];
        for (int g = 1; g < HGRPS; g++)
        begin
            hmax1 = max2(hmax1, hgrp1_reg[g]);
        end
        for (int g = 0; g < VGRPS; g++)
        begin
            m = $signed(line_q[g * GRP]);
            for (int k = 1; k < GRP; k++)
            begin
                if (g * GRP + k < HMAX_LINES)
                begin
                    m = max2(m, $signed(line_q[g * GRP + k]));
                end
            end
            vgrp1[g] = m;
        end
    end

    always_comb
    begin
        vmax2 = hmax2_reg;
        for (int g = 0; g < VGRPS; g++)
        begin
            vmax2 = max2(vmax2, vgrp2_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        last1_reg <= frame_last;
        pos1_reg  <= pos_ok;
        hw1_reg   <= h_ok;
        slot1_reg <= slot_h_reg;
        col1_reg  <= col_reg;
        cc1_reg   <= cc;
        cr1_reg   <= cr;
        for (int g = 0; g < HGRPS; g++)
        begin
            hgrp1_reg[g] <= hgrp[g];
        end

        last2_reg <= last1_reg;
        pos2_reg  <= pos1_reg;
        hw2_reg   <= hw1_reg;
        slot2_reg <= slot1_reg;
        col2_reg  <= col1_reg;
        cc2_reg   <= cc1_reg;
        cr2_reg   <= cr1_reg;
        hmax2_reg <= hmax1;
        cv2_reg   <= $signed(cq);
        for (int g = 0; g < VGRPS; g++)
        begin
            vgrp2_reg[g] <= vgrp1[g];
        end

        last3_reg <= last2_reg;
        pos3_reg  <= pos2_reg;
        cc3_reg   <= cc2_reg;
        cr3_reg   <= cr2_reg;
        cv3_reg   <= cv2_reg;
        vmax3_reg <= vmax2;
    end

    // decision
    assign key        = pos3_reg && (cv3_reg == vmax3_reg) && (cv3_reg > thr_s);
    assign push_valid = v3_reg && (key || last3_reg);

    always_comb
    begin
        push_item.is_keypoint = key;
        push_item.peak_x      = key ? cc3_reg : '0;
        push_item.peak_y      = key ? cr3_reg : '0;
        push_item.frame_end   = last3_reg;
    end

    assign inflight = INFLIGHT_W'(v1_reg) + INFLIGHT_W'(v2_reg) + INFLIGHT_W'(v3_reg);

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_last) |=> (col_reg == '0 && row_reg == '0 && slot_h_reg == '0))
        else $error("position not cleared after frame end");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_c_reg < SLOT_C_W'(CENTER_LINES)) && (slot_h_reg < SLOT_H_W'(HMAX_LINES)))
        else $error("row slot out of range");

endmodule

`default_nettype wire

/* hdl/hmpn_back.sv */
// ============================================================================
// hmpn_back: result queue and output register
// buffers decided results and presents them on the output channel
// ============================================================================
`default_nettype none

module hmpn_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push_valid,
    input  wire hmpn_pkg::result_t                 push_item,
    output logic [hmpn_pkg::FIFO_CNT_W-1:0]        fifo_count,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output hmpn_pkg::result_t                      out_item
);
    import hmpn_pkg::*;

    result_t                fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic                   out_valid_reg;
    result_t                out_item_reg;
    logic                   pop;

    assign pop = (cnt_reg != '0) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
        if (pop)
        begin
            out_item_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push_valid) - FIFO_CNT_W'(pop);
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign fifo_count = cnt_reg;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push_valid && cnt_reg == FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

/* hdl/heatmap_peak_nms.sv */
// ============================================================================
// heatmap_peak_nms: streaming max-pool peak finder for heatmaps
// thresholds pixels, finds window maxima and reports keypoint coordinates
// ============================================================================
// Pixels enter in raster order, one item per clock, and the block keeps that
// rate without gaps as long as the output side is not stalled. A result
// passes three pipeline stages, the first of which holds the registered
// line-buffer reads, and then the result queue before it reaches the output
// register. A center is decided by the pixel that completes its 20x20
// window, so keypoints come out in row-major order; the frame_last pixel
// always gives one result with frame_end set. The line buffers (19 rows of
// horizontal maxima and 10 rows of delayed pixels, 256 columns each) are
// not cleared at reset; every entry is written in a frame before it is
// read. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
`default_nettype none

module heatmap_peak_nms (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_write_en,
    input  wire logic [hmpn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hmpn_pkg::CFG_DATA_W-1:0]        cfg_data,
    // pixel input
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [hmpn_pkg::PIX_W-1:0]      pixel_value,
    input  wire logic                                   frame_last,
    // result output
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        is_keypoint,
    output logic [hmpn_pkg::COL_W-1:0]                  peak_x,
    output logic [hmpn_pkg::ROW_W-1:0]                  peak_y,
    output logic                                        frame_end
);
    import hmpn_pkg::*;

    logic [GEOM_W-1:0]   width_reg;
    logic [GEOM_W-1:0]   height_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [MARGIN_W-1:0] margin_reg;
    cfg_t                cfg;

    logic                  accept;
    logic                  push_valid;
    result_t               push_item;
    logic [INFLIGHT_W-1:0] inflight;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   occupancy;
    result_t               out_item;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= GEOM_W'(64);
            height_reg <= GEOM_W'(64);
            thr_reg    <= '0;
            margin_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:     width_reg  <= cfg_data[GEOM_W-1:0];
                CFG_HEIGHT:    height_reg <= cfg_data[GEOM_W-1:0];
                CFG_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                CFG_MARGIN:    margin_reg <= cfg_data[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // zero geometry acts as one, oversize is clamped to the buffer size
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = GEOM_W'(1);
        else if (width_reg > GEOM_W'(MAX_WIDTH))
            cfg.width = GEOM_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = GEOM_W'(1);
        else if (height_reg > GEOM_W'(MAX_HEIGHT))
            cfg.height = GEOM_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.threshold = thr_reg;
        cfg.margin    = margin_reg;
    end

    // credit check: every item in the pipe has a queue slot reserved
    assign occupancy = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(inflight);
    assign in_stall  = (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign accept    = in_valid && !in_stall;

    hmpn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .pixel_value (pixel_value),
        .frame_last  (frame_last),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .inflight    (inflight)
    );

    hmpn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .fifo_count (fifo_count),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_item   (out_item)
    );

    assign is_keypoint = out_item.is_keypoint;
    assign peak_x      = out_item.peak_x;
    assign peak_y      = out_item.peak_y;
    assign frame_end   = out_item.frame_end;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
        else $error("more items in flight than queue slots");

endmodule

`default_nettype wire

/* test/heatmap_peak_nms_tb.sv */
// ============================================================================
// heatmap_peak_nms_tb: self-checking bench for the heatmap peak finder
// streams whole and broken frames under random valid/stall gaps, predicts
// every result item with an in-bench window-max model and compares in order
// ============================================================================
`default_nettype none

module heatmap_peak_nms_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hmpn_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    pix_t                  pixel_value = '0;
    logic                  frame_last = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_keypoint;
    logic [COL_W-1:0]      peak_x;
    logic [ROW_W-1:0]      peak_y;
    logic                  frame_end;

    heatmap_peak_nms uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_value  (pixel_value),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_keypoint  (is_keypoint),
        .peak_x       (peak_x),
        .peak_y       (peak_y),
        .frame_end    (frame_end)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // peak predictor: own copy of line buffers, counters and registers
    // ------------------------------------------------------------------
    int hmax_store [HMAX_LINES*MAX_WIDTH];
    int pix_delay  [CENTER_LINES*MAX_WIDTH];
    int row_tail   [WINDOW];
    int col_pos, row_pos;
    int geom_w_reg, geom_h_reg, thr_reg, margin_reg;

    result_t peak_queue[$];

    int  n_errors, n_pixels, n_results, n_peaks, n_frames;
    bit  idle_on = 1'b1;
    bit  hold_go = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    int  planted[int];          // row*256+col -> forced pixel value
    bit  plain_background = 1'b0;

    // predict the result item (if any) of one accepted pixel
    task automatic predict_pixel(input pix_t pv, input bit last);
        int w, h, v, c, r, hm, vm, cr, cc, cv, i;
        bit hit;
        result_t res;
        w = (geom_w_reg == 0) ? 1 : (geom_w_reg > MAX_WIDTH) ? MAX_WIDTH : geom_w_reg;
        h = (geom_h_reg == 0) ? 1 : (geom_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : geom_h_reg;
        v = pv;
        c = col_pos;
        r = row_pos;
        hit = 1'b0;
        cr = 0;
        cc = 0;
        if (v < thr_reg)
            v = 0;
        for (i = 0; i < WINDOW-1; i++)
            row_tail[i] = row_tail[i+1];
        row_tail[WINDOW-1] = v;
        pix_delay[(r % CENTER_LINES)*MAX_WIDTH + c] = v;
        if (c >= WINDOW-1)
        begin
            hm = row_tail[0];
            for (i = 1; i < WINDOW; i++)
                if (row_tail[i] > hm)
                    hm = row_tail[i];
            vm = hm;
            if (r >= WINDOW-1)
            begin
                cr = r - (WINDOW-1) + HALF_WIN;
                cc = c - (WINDOW-1) + HALF_WIN;
                for (i = 0; i < HMAX_LINES; i++)
                    if (hmax_store[i*MAX_WIDTH + c] > vm)
                        vm = hmax_store[i*MAX_WIDTH + c];
                cv = pix_delay[(cr % CENTER_LINES)*MAX_WIDTH + cc];
                hit = cr >= HALF_WIN && cr < h - HALF_WIN && cc >= HALF_WIN &&
                      cc < w - HALF_WIN && cv == vm && cv > thr_reg &&
                      cc >= margin_reg && cr >= margin_reg &&
                      cr < h - margin_reg && cc < w - margin_reg;
            end
            hmax_store[(r % HMAX_LINES)*MAX_WIDTH + c] = hm;
        end
        if (last)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        else
        begin
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            col_pos = c;
            row_pos = r;
        end
        if (hit || last)
        begin
            res.is_keypoint = hit;
            res.peak_x      = hit ? cc[COL_W-1:0] : '0;
            res.peak_y      = hit ? cr[ROW_W-1:0] : '0;
            res.frame_end   = last;
            peak_queue = {peak_queue, res};
        end
    endtask

    // ------------------------------------------------------------------
    // result checker and output stall generator
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (out_valid && !out_stall && rst_n)
        begin
            n_results++;
            if (peak_queue.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected item kp=%0b x=%0d y=%0d end=%0b", $time,
                         is_keypoint, peak_x, peak_y, frame_end);
            end
            else
            begin
                want = peak_queue.pop_front();
                if (want.is_keypoint)
                    n_peaks++;
                if (want.is_keypoint !== is_keypoint || want.peak_x !== peak_x ||
                    want.peak_y !== peak_y || want.frame_end !== frame_end)
                begin
                    n_errors++;
                    $display("%0t: mismatch expected kp=%0b x=%0d y=%0d end=%0b",
                             $time, want.is_keypoint, want.peak_x, want.peak_y,
                             want.frame_end);
                    $display("%0t:          actual   kp=%0b x=%0d y=%0d end=%0b",
                             $time, is_keypoint, peak_x, peak_y, frame_end);
                end
            end
        end
        // random stall bursts, overridden by a long hold
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
        out_stall <= (hold_left > 0) || (stall_left > 0);
    end

    // long receiver hold, counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_go)
        begin
            hold_left <= HOLD_CYCLES;
            hold_go = 1'b0;
        end
    end

    // watchdog: cycles without any accepted item on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------
    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_WIDTH:     geom_w_reg = value & 'h1FF;
            CFG_HEIGHT:    geom_h_reg = value & 'h1FF;
            CFG_THRESHOLD: thr_reg    = value & 'h7FFF;
            CFG_MARGIN:    margin_reg = value & 'hFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int thr, input int mg);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MARGIN, mg);
    endtask

    // send one pixel item; valid stays high unless a gap is taken
    task automatic send_pixel(input pix_t pv, input bit last);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= pv;
        frame_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pixel(pv, last);
        n_pixels++;
    endtask

    // heatmap-like content: mostly low, some noise, sparse peaks
    function automatic pix_t pick_pixel();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3)
            return pix_t'($urandom_range(20000, 32767));
        else if (p < 10)
            return pix_t'($urandom);
        return pix_t'($urandom_range(0, 8000));
    endfunction

    // raster scan of count pixels over a w-wide frame
    task automatic send_frame(input int w, input int count, input bit last);
        int k, key;
        pix_t pv;
        for (k = 0; k < count; k++)
        begin
            key = (k / w) * 256 + (k % w);
            if (planted.exists(key))
                pv = pix_t'(planted[key]);
            else
                pv = plain_background ? pix_t'(0) : pick_pixel();
            send_pixel(pv, last && (k == count - 1));
        end
        if (last)
            n_frames++;
    endtask

    // wait until every expected result is back and the pipe is empty
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (peak_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // width and height at and beyond their limits
    task automatic test_geometry_limits();
        set_geometry(0, 5, 0, 0);           // width 0 acts as one column
        send_frame(1, 5, 1'b1);
        wait_drain();
        set_geometry(2, 0, 0, 0);           // height 0 acts as one row, rows wrap
        send_frame(2, 5, 1'b0);
        send_frame(2, 1, 1'b1);
        wait_drain();
        set_geometry('h1FF, 'h1FF, 0, 0);   // both clamp to 256
        send_frame(256, 6, 1'b1);
        wait_drain();
    endtask

    // receiver holds off while one-pixel frames keep producing items
    task automatic test_backpressure();
        set_geometry(24, 24, 0, 0);
        hold_go = 1'b1;
        repeat (24) send_frame(24, 1, 1'b1);
        wait_drain();
    endtask

    // small random frames: cut short or run past the configured end
    task automatic test_random_frames();
        int w, h, mode, pix0;
        pix0 = n_pixels;
        while (n_pixels - pix0 < 80)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            set_geometry(w, h, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 6000),
                         $urandom_range(0, 15));
            mode = $urandom_range(0, 9);
            if (mode < 6)
                send_frame(w, $urandom_range(1, w*h), 1'b1);
            else
            begin
                send_frame(w, w*h, 1'b0);
                send_frame(w, $urandom_range(1, 8), 1'b1);
            end
            wait_drain();
        end
    endtask

    // planted peaks on a flat floor: extremes, ties, threshold and margin edge
    task automatic test_planted_peaks();
        planted.delete();
        plain_background = 1'b1;
        set_geometry(22, 21, 'h1000, 10);
        planted[10*256 + 10] = 'h2000;      // tied pair, both centers
        planted[10*256 + 11] = 'h2000;
        planted[0*256 + 0]   = -32768;      // most negative, zeroed
        planted[20*256 + 21] = 32767;       // most positive, in no center window
        planted[5*256 + 5]   = 'h1000;      // equal to threshold: kept, not a peak
        send_frame(22, 22*21, 1'b1);
        wait_drain();
        planted.delete();
        plain_background = 1'b0;
    endtask

    // closing frames at full rate with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        set_geometry(8, 4, 'h600, 2);
        send_frame(8, 8*4, 1'b1);
        send_frame(8, 8*4, 1'b1);
        wait_drain();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < HMAX_LINES*MAX_WIDTH; i++)
            hmax_store[i] = 0;
        for (i = 0; i < CENTER_LINES*MAX_WIDTH; i++)
            pix_delay[i] = 0;
        for (i = 0; i < WINDOW; i++)
            row_tail[i] = 0;
        col_pos = 0;
        row_pos = 0;
        geom_w_reg = 64;
        geom_h_reg = 64;
        thr_reg = 0;
        margin_reg = 0;
        n_errors = 0;
        n_pixels = 0;
        n_results = 0;
        n_peaks = 0;
        n_frames = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_geometry_limits();
        test_backpressure();
        test_random_frames();
        test_planted_peaks();
        test_full_rate();

        if (peak_queue.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d expected items never arrived", $time, peak_queue.size());
        end
        $display("covered %0d pixels in %0d frames, %0d result items, %0d keypoints",
                 n_pixels, n_frames, n_results, n_peaks);
        $display("geometry clamps, cut and wrapped frames, tied peaks, long output hold");
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
